### src/stdf_pkg.sv
// Shared types and the double-dabble step for the score/time decimal formatter.
// No dependencies.
package stdf_pkg;

    localparam int BIN_W   = 32;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int DD_W    = BCD_W + BIN_W;

    typedef struct packed {
        logic        time_mode;
        logic [30:0] word;
    } stdf_word_t;

    typedef struct packed {
        logic                        time_mode;
        logic [DIGITS-1:0][3:0]      bcd;
    } stdf_digits_t;

    // one shift-add-3 step: upper BCD_W bits are BCD, lower BIN_W bits binary
    function automatic logic [DD_W-1:0] stdf_dd_step(input logic [DD_W-1:0] s);
        logic [DD_W-1:0] t;
        t = s;
        for (int k = 0; k < DIGITS; k++) begin
            if (t[BIN_W + 4*k +: 4] >= 4'd5) begin
                t[BIN_W + 4*k +: 4] = t[BIN_W + 4*k +: 4] + 4'd3;
            end
        end
        return {t[DD_W-2:0], 1'b0};
    endfunction

endpackage

### src/stdf_prep.sv
// Front stages: clamp; in time mode, split ms into min/s/ms and pack for BCD.
// Depends on stdf_pkg.
module stdf_prep
    import stdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] in_value,
    input  logic        in_time_mode,
    output logic        out_valid,
    output stdf_word_t  out_item
);

    localparam logic [30:0] MIN_SAT   = 31'd6000000;
    localparam logic [23:0] RECIP_MS  = 24'd8589935;
    localparam logic [13:0] RECIP_MIN = 14'd8739;
    localparam logic [23:0] SAT_WORD  = 24'd9999999;

    logic [4:0]  valid_reg;

    logic [30:0] v1_reg, v2_reg, v3_reg, v4_reg;
    logic [4:0]  mode_reg;
    logic [3:0]  sat_reg;
    logic [12:0] q2_reg;
    logic [9:0]  ms3_reg, ms4_reg;
    logic [6:0]  mins3_reg, mins4_reg;
    logic [5:0]  secs4_reg;
    logic [30:0] word_reg;

    logic [30:0] v1_next;
    logic        sat1_next;
    logic [46:0] prod_ms;
    logic [12:0] q2_next;
    logic [22:0] ms_wide;
    logic [26:0] prod_min;
    logic [23:0] t_next;
    logic [30:0] word_next;

    always_comb begin
        v1_next   = in_value[31] ? 31'd0 : in_value[30:0];
        sat1_next = (v1_next >= MIN_SAT);
        prod_ms   = 47'(v1_reg[22:0]) * 47'(RECIP_MS);
        q2_next   = prod_ms[45:33];
        ms_wide   = v2_reg[22:0] - 23'(q2_reg * 23'd1000);
        prod_min  = 27'(q2_reg) * 27'(RECIP_MIN);
        t_next    = 24'(mins4_reg) * 24'd100000 + 24'(secs4_reg) * 24'd1000
                  + 24'(ms4_reg);
        if (!mode_reg[3]) begin
            word_next = v4_reg;
        end else if (sat_reg[3]) begin
            word_next = 31'(SAT_WORD);
        end else begin
            word_next = 31'(t_next);
        end
    end

    logic [12:0] q3_reg;
    logic [12:0] secs_wide;
    assign secs_wide = q3_reg - 13'(mins3_reg * 13'd60);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg    <= v1_next;
            mode_reg  <= {mode_reg[3:0], in_time_mode};
            sat_reg   <= {sat_reg[2:0], sat1_next};
            v2_reg    <= v1_reg;
            q2_reg    <= q2_next;
            v3_reg    <= v2_reg;
            q3_reg    <= q2_reg;
            ms3_reg   <= ms_wide[9:0];
            mins3_reg <= prod_min[25:19];
            v4_reg    <= v3_reg;
            mins4_reg <= mins3_reg;
            secs4_reg <= secs_wide[5:0];
            ms4_reg   <= ms3_reg;
            word_reg  <= word_next;
        end
    end

    assign out_valid          = valid_reg[4];
    assign out_item.time_mode = mode_reg[4];
    assign out_item.word      = word_reg;

endmodule

### src/stdf_bcd.sv
// Eight-stage double-dabble converter, four shift-add-3 steps per stage.
// Depends on stdf_pkg.
module stdf_bcd
    import stdf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  stdf_word_t   in_item,
    output logic         out_valid,
    output stdf_digits_t out_item
);

    localparam int STAGES = 8;
    localparam int STEPS  = BIN_W / STAGES;

    logic [STAGES-1:0]           valid_reg;
    logic [STAGES-1:0]           mode_reg;
    logic [STAGES-1:0][DD_W-1:0] dd_reg;
    logic [STAGES-1:0][DD_W-1:0] dd_next;

    always_comb begin
        logic [DD_W-1:0] t;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                t = {{BCD_W{1'b0}}, 1'b0, in_item.word};
            end else begin
                t = dd_reg[(s == 0) ? 0 : s - 1];
            end
            for (int k = 0; k < STEPS; k++) begin
                t = stdf_dd_step(t);
            end
            dd_next[s] = t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg <= {mode_reg[STAGES-2:0], in_item.time_mode};
            dd_reg   <= dd_next;
        end
    end

    assign out_valid          = valid_reg[STAGES-1];
    assign out_item.time_mode = mode_reg[STAGES-1];
    assign out_item.bcd       = dd_reg[STAGES-1][DD_W-1:BIN_W];

endmodule

### src/stdf_ser.sv
// Character serialiser: turns ten BCD digits into a run of ASCII characters.
// Depends on stdf_pkg.
module stdf_ser
    import stdf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  stdf_digits_t in_item,
    output logic         in_ready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic         m_tlast
);

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [3:0] POS_TIME_LAST = 4'd8;
    localparam logic [3:0] POS_MAX       = 4'd9;

    logic         busy_reg,  busy_next;
    logic [3:0]   pos_reg,   pos_next;
    stdf_digits_t item_reg,  item_next;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [6:0]   m_char_reg,   m_char_next;
    logic         m_last_reg,   m_last_next;

    logic         out_free;
    logic         emit;
    logic         load;
    logic [3:0]   dig;
    logic [6:0]   cur_char;
    logic         cur_last;
    logic [3:0]   msd;

    always_comb begin
        dig = (pos_reg <= POS_MAX) ? item_reg.bcd[pos_reg] : 4'd0;
        if (item_reg.time_mode) begin
            cur_last = (pos_reg == POS_TIME_LAST);
            case (pos_reg)
                4'd0:    cur_char = (item_reg.bcd[6] == 4'd0) ? CH_SPACE
                                                              : {3'b011, item_reg.bcd[6]};
                4'd1:    cur_char = {3'b011, item_reg.bcd[5]};
                4'd2:    cur_char = CH_COLON;
                4'd3:    cur_char = {3'b011, item_reg.bcd[4]};
                4'd4:    cur_char = {3'b011, item_reg.bcd[3]};
                4'd5:    cur_char = CH_DOT;
                4'd6:    cur_char = {3'b011, item_reg.bcd[2]};
                4'd7:    cur_char = {3'b011, item_reg.bcd[1]};
                4'd8:    cur_char = {3'b011, item_reg.bcd[0]};
                default: cur_char = CH_SPACE;
            endcase
        end else begin
            cur_last = (pos_reg == 4'd0);
            cur_char = {3'b011, dig};
        end

        msd = 4'd0;
        for (int k = 1; k < DIGITS; k++) begin
            if (in_item.bcd[k] != 4'd0) begin
                msd = 4'(k);
            end
        end

        out_free = !m_tvalid_reg || m_tready;
        emit     = busy_reg && out_free;
        in_ready = !busy_reg || (out_free && cur_last);
        load     = in_valid && in_ready;

        busy_next     = busy_reg;
        pos_next      = pos_reg;
        item_next     = item_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;

        if (emit) begin
            m_tvalid_next = 1'b1;
            m_char_next   = cur_char;
            m_last_next   = cur_last;
            if (cur_last) begin
                busy_next = 1'b0;
            end else if (item_reg.time_mode) begin
                pos_next = pos_reg + 4'd1;
            end else begin
                pos_next = pos_reg - 4'd1;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            item_next = in_item;
            pos_next  = in_item.time_mode ? 4'd0 : msd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

    a_load_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && busy_reg) |-> (out_free && cur_last))
        else $error("new transaction loaded mid-run");

    a_time_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && item_reg.time_mode) |-> (pos_reg <= POS_TIME_LAST))
        else $error("time position out of range");

    a_dec_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !item_reg.time_mode) |-> (pos_reg <= POS_MAX))
        else $error("decimal position out of range");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && cur_last && !load) |=> !busy_reg)
        else $error("run did not end after last character");

endmodule

### src/score_time_decimal_formatter_core.sv
// Score/time decimal formatter, top level: prep stages, BCD pipeline, serialiser.
// An item passes the prep stages, BCD stages and serialiser item/char registers.
// Throughput: one character per cycle while m_tready is high; a run has
// 9 characters in time mode and 1 to 10 in decimal mode, set by the serialiser.
// Reset clears all valid bits and the serialiser's busy flag; no clearing pass.
// Depends on stdf_pkg, stdf_prep, stdf_bcd, stdf_ser.
module score_time_decimal_formatter_core
    import stdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [0:0]  s_tuser,   // [0] time_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
    output logic        m_tlast
);

    logic         en;
    logic         prep_valid;
    stdf_word_t   prep_item;
    logic         bcd_valid;
    stdf_digits_t bcd_item;
    logic         ser_ready;

    assign en       = !bcd_valid || ser_ready;
    assign s_tready = en;

    stdf_prep u_prep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .in_value     (s_tdata),
        .in_time_mode (s_tuser[0]),
        .out_valid    (prep_valid),
        .out_item     (prep_item)
    );

    stdf_bcd u_bcd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .in_item   (prep_item),
        .out_valid (bcd_valid),
        .out_item  (bcd_item)
    );

    stdf_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (bcd_valid),
        .in_item  (bcd_item),
        .in_ready (ser_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
